@@ rtl/qsd_pkg.sv @@
// shared types, constants and lookup tables of the slice decoder
`default_nettype none

package qsd_pkg;

    localparam int SLICE_LEN    = 20;
    localparam int CHANNELS_DEF = 2;
    localparam int IN_DATA_W    = 200;
    localparam int OUT_DATA_W   = 24;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    typedef logic signed [15:0] t_s16;

    typedef struct packed {
        t_s16 [3:0] hist;
        t_s16 [3:0] wt;
    } t_chan_state;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_ACC,
        ST_UPD,
        ST_OUT
    } t_state;

    function automatic logic [11:0] scale_lut(input logic [3:0] idx);
        logic [11:0] v;
        unique case (idx)
            4'd0:    v = 12'd1;
            4'd1:    v = 12'd7;
            4'd2:    v = 12'd21;
            4'd3:    v = 12'd45;
            4'd4:    v = 12'd84;
            4'd5:    v = 12'd138;
            4'd6:    v = 12'd211;
            4'd7:    v = 12'd304;
            4'd8:    v = 12'd421;
            4'd9:    v = 12'd562;
            4'd10:   v = 12'd731;
            4'd11:   v = 12'd928;
            4'd12:   v = 12'd1157;
            4'd13:   v = 12'd1419;
            4'd14:   v = 12'd1715;
            default: v = 12'd2048;
        endcase
        return v;
    endfunction

    // dequantization step times four
    function automatic logic signed [5:0] deq4_lut(input logic [2:0] code);
        logic signed [5:0] v;
        unique case (code)
            3'd0:    v = 6'sd3;
            3'd1:    v = -6'sd3;
            3'd2:    v = 6'sd10;
            3'd3:    v = -6'sd10;
            3'd4:    v = 6'sd18;
            3'd5:    v = -6'sd18;
            3'd6:    v = 6'sd28;
            default: v = -6'sd28;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/qsd_mac.sv @@
// shared signed 16x16 multiplier with registered product
`default_nettype none

module qsd_mac
    import qsd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic signed [15:0] i_a,
    input  wire logic signed [15:0] i_b,
    output logic signed [31:0]      o_prod
);

    logic signed [31:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

@@ rtl/qsd_store.sv @@
// per-channel predictor state memory with row valid bits
`default_nettype none

module qsd_store
    import qsd_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF,
    parameter int ROW_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr_en,
    input  wire logic [ROW_W-1:0] i_wr_row,
    input  wire t_chan_state      i_wr_data,
    input  wire logic [ROW_W-1:0] i_rd_row,
    output t_chan_state           o_rd_data
);

    t_chan_state          r_mem [CHANNELS];
    logic [CHANNELS-1:0]  r_vld;
    t_chan_state          r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_row] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_row] <= i_wr_data;
        end
        r_rd_data <= r_vld[i_rd_row] ? r_mem[i_rd_row] : '0;
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ rtl/qoa_slice_lms_decoder.sv @@
// a decode slice reads the channel state, then for each sample runs five products
// on the shared multiplier, an accumulate step and a weight update, then offers the
// sample; the next sample starts only once it is accepted, and input is not ready
// until the slice ends; loads are written to channel state as they are accepted
// synchronous active low reset idles control; all channel state then reads as zero
`default_nettype none

module qoa_slice_lms_decoder
    import qsd_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // slice_word, sample_count, hist_0..hist_3, wt_0..wt_3, zero pad
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // func, channel
    input  wire logic [1:0]            s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // sample, sample_index, zero pad
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // out_channel
    output logic                       m_axis_tuser,
    output logic                       m_axis_tlast
);

    localparam int ROW_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    t_state             r_state, n_state;
    logic [2:0]         r_step, n_step;
    logic [4:0]         r_idx, n_idx;
    logic [4:0]         r_cnt, n_cnt;
    logic               r_ch, n_ch;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [59:0]        r_codes, n_codes;
    logic [11:0]        r_sf, n_sf;
    t_chan_state        r_work, n_work;
    logic signed [33:0] r_acc, n_acc;
    t_s16               r_res, n_res;
    t_s16               r_out_sample, n_out_sample;
    logic [4:0]         r_out_idx, n_out_idx;
    logic               r_out_last, n_out_last;

    logic               out_acc, in_func, in_ch, ch_ok;
    logic [4:0]         in_cnt;
    logic [ROW_W-1:0]   in_row;
    t_chan_state        in_state, rd_data, wr_data;
    logic               wr_en;
    logic [ROW_W-1:0]   wr_row;
    logic signed [15:0] mul_a, mul_b;
    logic signed [31:0] prod;
    logic signed [5:0]  deq;
    logic [17:0]        mag, rnd;
    logic signed [21:0] psum;
    t_s16               smp, delta;
    logic               is_last;

    assign in_func = s_axis_tuser[0];
    assign in_ch   = s_axis_tuser[1];
    assign in_cnt  = s_axis_tdata[68:64];
    assign in_row  = ROW_W'(in_ch);
    assign ch_ok   = (32'(in_ch) < CHANNELS);
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign is_last = ((r_idx + 5'd1) == r_cnt);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            in_state.hist[k] = s_axis_tdata[69 + 16*k +: 16];
            in_state.wt[k]   = s_axis_tdata[133 + 16*k +: 16];
        end
    end

    qsd_store #(
        .CHANNELS (CHANNELS),
        .ROW_W    (ROW_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_row  (wr_row),
        .i_wr_data (wr_data),
        .i_rd_row  (in_row),
        .o_rd_data (rd_data)
    );

    qsd_mac u_mac (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // operand select for the shared multiplier
    assign deq = deq4_lut(r_codes[59:57]);
    always_comb begin
        unique case (r_step)
            3'd0:    begin mul_a = $signed({4'b0, r_sf});   mul_b = 16'(deq);          end
            3'd1:    begin mul_a = r_work.hist[0];           mul_b = r_work.wt[0];      end
            3'd2:    begin mul_a = r_work.hist[1];           mul_b = r_work.wt[1];      end
            3'd3:    begin mul_a = r_work.hist[2];           mul_b = r_work.wt[2];      end
            default: begin mul_a = r_work.hist[3];           mul_b = r_work.wt[3];      end
        endcase
    end

    // residual rounding, half away from zero
    assign mag = prod[31] ? 18'(-prod) : 18'(prod);
    assign rnd = (mag + 18'd2) >> 2;

    assign psum  = 22'($signed(r_acc[33:13])) + 22'(r_res);
    assign delta = $signed({{4{r_res[15]}}, r_res[15:4]});
    always_comb begin
        if (psum > 22'sd32767) begin
            smp = 16'sh7fff;
        end else if (psum < -22'sd32768) begin
            smp = 16'sh8000;
        end else begin
            smp = psum[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step       <= n_step;
        r_idx        <= n_idx;
        r_cnt        <= n_cnt;
        r_ch         <= n_ch;
        r_row        <= n_row;
        r_codes      <= n_codes;
        r_sf         <= n_sf;
        r_work       <= n_work;
        r_acc        <= n_acc;
        r_res        <= n_res;
        r_out_sample <= n_out_sample;
        r_out_idx    <= n_out_idx;
        r_out_last   <= n_out_last;
    end

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_ch         = r_ch;
        n_row        = r_row;
        n_codes      = r_codes;
        n_sf         = r_sf;
        n_work       = r_work;
        n_acc        = r_acc;
        n_res        = r_res;
        n_out_sample = r_out_sample;
        n_out_idx    = r_out_idx;
        n_out_last   = r_out_last;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        wr_en   = 1'b0;
        wr_row  = r_row;
        wr_data = n_work;

        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                wr_row  = in_row;
                wr_data = in_state;
                if (s_axis_tvalid && ch_ok) begin
                    if (in_func == FUNC_LOAD) begin
                        wr_en = 1'b1;
                    end else begin
                        n_ch    = in_ch;
                        n_row   = in_row;
                        n_sf    = scale_lut(s_axis_tdata[63:60]);
                        n_codes = s_axis_tdata[59:0];
                        n_cnt   = (in_cnt > 5'(SLICE_LEN)) ? 5'(SLICE_LEN) : in_cnt;
                        n_idx   = '0;
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                n_work = rd_data;
                n_step = '0;
                n_acc  = '0;
                n_state = (r_cnt == 5'd0) ? ST_IDLE : ST_MUL;
            end
            ST_MUL: begin
                if (r_step == 3'd1) begin
                    n_res = prod[31] ? 16'(-$signed({1'b0, rnd})) : 16'(rnd);
                end else if (r_step != 3'd0) begin
                    n_acc = r_acc + 34'(prod);
                end
                n_step = r_step + 3'd1;
                if (r_step == 3'd4) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                n_acc   = r_acc + 34'(prod);
                n_state = ST_UPD;
            end
            ST_UPD: begin
                for (int k = 0; k < 4; k++) begin
                    n_work.wt[k] = r_work.hist[k][15] ? r_work.wt[k] - delta
                                                      : r_work.wt[k] + delta;
                end
                for (int k = 0; k < 3; k++) begin
                    n_work.hist[k] = r_work.hist[k+1];
                end
                n_work.hist[3] = smp;
                n_out_sample = smp;
                n_out_idx    = r_idx;
                n_out_last   = is_last;
                n_codes      = {r_codes[56:0], 3'b000};
                n_idx        = r_idx + 5'd1;
                wr_en        = is_last;
                wr_data      = n_work;
                n_state      = ST_OUT;
            end
            ST_OUT: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) begin
                    n_step  = '0;
                    n_acc   = '0;
                    n_state = r_out_last ? ST_IDLE : ST_MUL;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tdata = {3'b000, r_out_idx, r_out_sample};
    assign m_axis_tuser = r_ch;
    assign m_axis_tlast = r_out_last;

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a sample is pending");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> (r_step <= 3'd4))
        else $error("multiply step out of range");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_out_idx < r_cnt))
        else $error("sample index beyond slice count");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && m_axis_tlast) |=> s_axis_tready)
        else $error("decoder not idle after final sample");

    a_wr_when: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> ((r_state == ST_IDLE) || (r_state == ST_UPD && is_last)))
        else $error("state write outside load or slice end");

endmodule

`default_nettype wire

@@ tb/sv/qoa_slice_lms_decoder_tb.sv @@
// self-checking testbench for the two-channel slice decoder with lms prediction
module qoa_slice_lms_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import qsd_pkg::*;

    typedef struct {
        logic        func;
        logic        chan;
        logic [63:0] word;
        logic [4:0]  cnt;
        t_chan_state st;
        bit          wait_drain;
    } slice_item_t;

    typedef struct {
        t_s16       smp;
        logic       chan;
        logic [4:0] idx;
        logic       last;
    } pcm_sample_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // slice_word, sample_count, hist_0..hist_3, wt_0..wt_3, zero pad
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // func, channel
    logic [1:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // sample, sample_index, zero pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // out_channel
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    int          scale_tab [16] = '{1, 7, 21, 45, 84, 138, 211, 304,
                                    421, 562, 731, 928, 1157, 1419, 1715, 2048};
    int          deq4_tab [8] = '{3, -3, 10, -10, 18, -18, 28, -28};
    t_s16        hist_mem [8] = '{default: '0};
    t_s16        wt_mem [8] = '{default: '0};
    slice_item_t pending_slices [$];
    pcm_sample_t expected_pcm [$];
    slice_item_t cur_item;
    logic        in_taken = 1'b0;
    int          in_count = 0;
    int          fail_cnt = 0;
    logic        rx_block = 1'b0;
    logic        quiet;

    assign quiet = (in_count >= 120 && in_count < 160);

    qoa_slice_lms_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $realtime, msg);
        fail_cnt++;
    endtask

    task automatic queue_slice(input slice_item_t it);
        pending_slices = {pending_slices, it};
    endtask

    task automatic load_channel(input slice_item_t it);
        int b;
        b = int'(it.chan) * 4;
        for (int k = 0; k < 4; k++) begin
            hist_mem[b + k] = it.st.hist[k];
            wt_mem[b + k]   = it.st.wt[k];
        end
    endtask

    task automatic decode_slice(input slice_item_t it);
        int          n, b, sf, code, prod, r, d, wv;
        longint      acc;
        pcm_sample_t s;
        n  = (it.cnt > SLICE_LEN) ? SLICE_LEN : int'(it.cnt);
        b  = int'(it.chan) * 4;
        sf = scale_tab[it.word[63:60]];
        for (int i = 0; i < n; i++) begin
            code = int'((it.word >> (57 - 3 * i)) & 64'd7);
            prod = sf * deq4_tab[code];
            if (prod >= 0) begin
                r = (prod + 2) >>> 2;
            end else begin
                r = -((-prod + 2) >>> 2);
            end
            acc = 0;
            for (int k = 0; k < 4; k++) begin
                acc += longint'(hist_mem[b + k]) * longint'(wt_mem[b + k]);
            end
            acc = (acc >>> 13) + r;
            if (acc < -32768) acc = -32768;
            if (acc > 32767) acc = 32767;
            d = r >>> 4;
            for (int k = 0; k < 4; k++) begin
                wv = int'(wt_mem[b + k]) + ((hist_mem[b + k] < 0) ? -d : d);
                wt_mem[b + k] = wv[15:0];
            end
            for (int k = 0; k < 3; k++) begin
                hist_mem[b + k] = hist_mem[b + k + 1];
            end
            hist_mem[b + 3] = acc[15:0];
            s.smp  = acc[15:0];
            s.chan = it.chan;
            s.idx  = i[4:0];
            s.last = (i + 1 == n);
            expected_pcm = {expected_pcm, s};
        end
    endtask

    function automatic slice_item_t mk_load(input logic ch, input t_chan_state st);
        slice_item_t it;
        it.func = FUNC_LOAD;
        it.chan = ch;
        it.word = {$urandom, $urandom};
        it.cnt  = 5'($urandom);
        it.st   = st;
        it.wait_drain = 1'b0;
        return it;
    endfunction

    function automatic slice_item_t mk_decode(input logic ch, input logic [63:0] w,
                                              input logic [4:0] cnt);
        slice_item_t it;
        it.func = FUNC_DECODE;
        it.chan = ch;
        it.word = w;
        it.cnt  = cnt;
        it.st   = {$urandom, $urandom, $urandom, $urandom};
        it.wait_drain = 1'b0;
        return it;
    endfunction

    // negative code selects a walk through all eight codes
    function automatic logic [63:0] mk_word(input logic [3:0] scale, input int code);
        logic [63:0] w;
        w = '0;
        w[63:60] = scale;
        for (int i = 0; i < 20; i++) begin
            w[57 - 3 * i +: 3] = (code < 0) ? 3'(i % 8) : 3'(code);
        end
        return w;
    endfunction

    function automatic t_chan_state mk_state(input bit typical);
        t_chan_state st;
        if (typical) begin
            for (int k = 0; k < 4; k++) begin
                st.hist[k] = 16'($urandom_range(4000) - 2000);
            end
            st.wt[0] = 16'($urandom_range(512) - 256);
            st.wt[1] = 16'($urandom_range(1024) - 512);
            st.wt[2] = 16'(-8192 + $urandom_range(2048) - 1024);
            st.wt[3] = 16'(16384 + $urandom_range(2048) - 1024);
        end else begin
            st = {$urandom, $urandom, $urandom, $urandom};
        end
        return st;
    endfunction

    // driver: next transaction offered at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (pending_slices.size() != 0
                && !(pending_slices[0].wait_drain && expected_pcm.size() != 0)
                && (quiet || $urandom_range(99) >= 28)) begin
                cur_item = pending_slices.pop_front();
                s_axis_tdata  <= {3'b000, cur_item.st.wt[3], cur_item.st.wt[2],
                                  cur_item.st.wt[1], cur_item.st.wt[0],
                                  cur_item.st.hist[3], cur_item.st.hist[2],
                                  cur_item.st.hist[1], cur_item.st.hist[0],
                                  cur_item.cnt, cur_item.word};
                s_axis_tuser  <= {cur_item.chan, cur_item.func};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver backpressure
    always @(negedge i_clk) begin
        if (!i_rst_n || rx_block) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= quiet || ($urandom_range(99) >= 28);
        end
    end

    // monitor: input transactions feed the predictor, output transactions are checked
    always @(posedge i_clk) begin
        pcm_sample_t want;
        in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            in_count <= in_count + 1;
            if (cur_item.func == FUNC_LOAD) begin
                load_channel(cur_item);
            end else begin
                decode_slice(cur_item);
            end
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_pcm.size() == 0) begin
                report_mismatch($sformatf("sample %0d on channel %0d with none pending",
                                          $signed(m_axis_tdata[15:0]), m_axis_tuser));
            end else begin
                want = expected_pcm.pop_front();
                if (m_axis_tdata[15:0] !== want.smp)
                    report_mismatch($sformatf("sample got %0d want %0d",
                                              $signed(m_axis_tdata[15:0]), want.smp));
                if (m_axis_tdata[20:16] !== want.idx)
                    report_mismatch($sformatf("index got %0d want %0d",
                                              m_axis_tdata[20:16], want.idx));
                if (m_axis_tuser !== want.chan)
                    report_mismatch($sformatf("channel got %0d want %0d",
                                              m_axis_tuser, want.chan));
                if (m_axis_tlast !== want.last)
                    report_mismatch($sformatf("last got %0d want %0d at index %0d",
                                              m_axis_tlast, want.last, want.idx));
            end
        end
    end

    // long receiver hold-off so the decoder backs up into its input
    initial begin
        wait (in_count >= 60);
        @(posedge i_clk);
        rx_block = 1'b1;
        repeat (400) @(posedge i_clk);
        rx_block = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        t_chan_state st;
        slice_item_t it;
        int          kind;
        logic [4:0]  cnt;

        // decode from the cleared state, both channels, all codes
        queue_slice(mk_decode(1'b0, mk_word(4'd15, -1), 5'd20));
        queue_slice(mk_decode(1'b1, mk_word(4'd0, -1), 5'd20));
        // prediction saturating high
        st.hist = {4{16'sh7fff}};
        st.wt   = {4{16'sh7fff}};
        queue_slice(mk_load(1'b0, st));
        queue_slice(mk_decode(1'b0, '1, 5'd4));
        // prediction saturating low, count above slice length
        st.hist = {4{16'sh8000}};
        queue_slice(mk_load(1'b1, st));
        queue_slice(mk_decode(1'b1, '0, 5'd31));
        // most negative operands
        st.wt = {4{16'sh8000}};
        queue_slice(mk_load(1'b0, st));
        queue_slice(mk_decode(1'b0, {$urandom, $urandom}, 5'd21));
        // zero count leaves state alone
        queue_slice(mk_decode(1'b0, '1, 5'd0));
        queue_slice(mk_decode(1'b0, mk_word(4'd7, 3), 5'd1));
        // negative history reverses the direction of weight updates
        st.hist = {16'sd2000, -16'sd300, 16'sd100, -16'sd5};
        st.wt   = {16'sd16384, -16'sd8192, 16'sd0, 16'sd0};
        queue_slice(mk_load(1'b1, st));
        queue_slice(mk_decode(1'b1, mk_word(4'd15, -1), 5'd20));
        // largest positive residual wraps weights past the top
        st.hist = {4{16'sd1000}};
        st.wt   = {4{16'sh7f00}};
        queue_slice(mk_load(1'b0, st));
        queue_slice(mk_decode(1'b0, mk_word(4'd15, 6), 5'd20));
        queue_slice(mk_decode(1'b1, mk_word(4'd15, 7), 5'd20));

        for (int n = 0; n < 200; n++) begin
            kind = $urandom_range(99);
            if (kind < 20) begin
                it = mk_load(1'($urandom), mk_state(kind < 14));
            end else begin
                kind = $urandom_range(99);
                if (kind < 6) cnt = 5'd0;
                else if (kind < 12) cnt = 5'($urandom_range(31, 21));
                else if (kind < 30) cnt = 5'd20;
                else cnt = 5'($urandom_range(19, 1));
                it = mk_decode(1'($urandom), {$urandom, $urandom}, cnt);
            end
            it.wait_drain = (n == 100);
            queue_slice(it);
        end

        while (pending_slices.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_pcm.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/qsd_pkg.sv
rtl/qsd_mac.sv
rtl/qsd_store.sv
rtl/qoa_slice_lms_decoder.sv
tb/sv/qoa_slice_lms_decoder_tb.sv
